// ===== hw/rtl/zih_pkg.sv =====
package zih_pkg;

    // Table geometry.
    localparam int SLOTS    = 16;
    localparam int KEY_BITS = 8;
    localparam int GROUPS   = 16;

    // Field widths of the stream words.
    localparam int HASH_W  = 64;
    localparam int VAL_W   = 8;
    localparam int SLOT_W  = 4;
    localparam int GROUP_W = 4;
    localparam int MASK_W  = 16;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 5;

    // Derived sizes of the key memory and the slot count.
    localparam int ROW_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W = ROW_W + KEY_BITS;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int GSEL_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    // The rehash row is reduced one byte of the seed per cycle.
    localparam int DIGIT_W   = 8;
    localparam int MOD_STEPS = HASH_W / DIGIT_W;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(16);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_KEY  = 2'd0,
        KIND_LOAD_MASK = 2'd1,
        KIND_ELEMENT   = 2'd2,
        KIND_REHASH    = 2'd3
    } t_kind;

    // Effective slot count: zero acts as one, anything above SLOTS as SLOTS.
    function automatic logic [CNT_W-1:0] slot_count(input logic [CFG_W-1:0] cfg);
        logic [CFG_W-1:0] n;
        n = cfg;
        if (n == '0) begin
            n = CFG_W'(1);
        end
        if (int'(n) > SLOTS) begin
            n = CFG_W'(SLOTS);
        end
        return CNT_W'(n);
    endfunction

endpackage

// ===== hw/rtl/zih_stream_if.sv =====
// Input channel: one word per accepted item.
interface zih_in_if
    import zih_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot;
    logic [VAL_W-1:0]     old_value;
    logic [VAL_W-1:0]     new_value;
    logic [GROUP_W-1:0]   group;
    logic                 whole_vector;
    logic                 first_of_vector;
    logic                 last_of_vector;
    logic                 no_previous;
    logic [HASH_W-1:0]    hash_in;
    logic [HASH_W-1:0]    key_word;
    logic [MASK_W-1:0]    group_mask;

    modport source (
        output valid, kind, slot, old_value, new_value, group, whole_vector,
               first_of_vector, last_of_vector, no_previous, hash_in, key_word,
               group_mask,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, old_value, new_value, group, whole_vector,
               first_of_vector, last_of_vector, no_previous, hash_in, key_word,
               group_mask,
        output ready
    );
endinterface

// Output channel: one word per finished hash.
interface zih_out_if
    import zih_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_out;

    modport source (output valid, hash_out, input ready);
    modport sink (input valid, hash_out, output ready);
endinterface

// ===== hw/rtl/zobrist_incremental_hash.sv =====
// Incremental Zobrist hash engine.
// Words arrive on i_in (valid/ready); a word is taken when both are high.
// Load words fill the key memory and the group mask table, element words
// update the running hash, and the last element of a vector or a rehash word
// produces one word on o_out (valid/ready). i_cfg_we/i_cfg_wdata set the
// number of slots in use.
// Per word: a load is written into its table as it is taken, an element reads
// the key memory and then XORs both keys into the running hash, and a rehash
// latches the seed, reduces it byte by byte over its eight bytes with the key
// read issued in the last step, then XORs the key into the output register.
// A result is in the output register the cycle after its last working cycle.
// The output register decouples the two sides: new words are accepted while
// a result waits. When the receiver stalls and a second result is ready,
// the engine holds in its working state until the output register frees up.
// Reset clears the control state, the running hash and the zero flag, and
// sets the slot count to 16. Key memory and masks hold garbage until loaded.
module zobrist_incremental_hash
    import zih_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    zih_in_if.sink           i_in,
    zih_out_if.source        o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ELEM,
        S_MOD,
        S_REHASH
    } t_state;

    t_state r_state;

    // Latched item fields.
    logic [SLOT_W-1:0]  r_slot;
    logic [VAL_W-1:0]   r_old;
    logic [VAL_W-1:0]   r_new;
    logic [GROUP_W-1:0] r_group;
    logic               r_whole;
    logic               r_first;
    logic               r_last;
    logic               r_nprev;
    logic [HASH_W-1:0]  r_hin;

    // Rehash modulo state.
    logic [HASH_W-1:0] r_digits;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;

    // Architectural state.
    logic [HASH_W-1:0] r_run_hash;
    logic              r_zero;
    logic [CFG_W-1:0]  r_slots_cfg;

    // Output register.
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_hash;

    // Memories and their registered read data.
    logic [HASH_W-1:0] key_mem [2**ADDR_W];
    logic [MASK_W-1:0] mask_mem [GROUPS];
    logic [HASH_W-1:0] r_rd_a;
    logic [HASH_W-1:0] r_rd_b;
    logic [MASK_W-1:0] r_sel_mask;

    logic               in_acc;
    logic               out_free;
    logic               out_load;
    logic [CNT_W-1:0]   cnt;
    logic               key_we;
    logic [ADDR_W-1:0]  key_waddr;
    logic               mask_we;
    logic               rd_en_a;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic               rd_en_b;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic [CNT_W-1:0]   n_rem;
    logic [KEY_BITS-1:0] rehash_col;
    logic               in_use;
    logic               contrib;
    logic [HASH_W-1:0]  base_hash;
    logic [HASH_W-1:0]  n_run_hash;
    logic               n_zero;

    // One byte of the seed folded into the remainder: eight compare-subtracts.
    function automatic logic [CNT_W-1:0] mod_digit(
        input logic [CNT_W-1:0]   rem,
        input logic [DIGIT_W-1:0] digit,
        input logic [CNT_W-1:0]   n
    );
        logic [CNT_W+DIGIT_W-1:0] v;
        logic [CNT_W+DIGIT_W-1:0] sub;
        v = {rem, digit};
        for (int k = DIGIT_W - 1; k >= 0; k--) begin
            sub = (CNT_W + DIGIT_W)'(n) << k;
            if (v >= sub) begin
                v = v - sub;
            end
        end
        return v[CNT_W-1:0];
    endfunction

    // Handshake status.
    assign in_acc    = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign cnt       = slot_count(r_slots_cfg);

    // The output register takes a new result in this cycle.
    assign out_load  = out_free && (((r_state == S_ELEM) && r_last) || (r_state == S_REHASH));

    // Table writes happen on the edge that takes the load word.
    assign key_we    = in_acc && (i_in.kind == KIND_LOAD_KEY) && (int'(i_in.slot) < SLOTS);
    assign key_waddr = {ROW_W'(i_in.slot), KEY_BITS'(i_in.new_value)};
    assign mask_we   = in_acc && (i_in.kind == KIND_LOAD_MASK) && (int'(i_in.group) < GROUPS);

    // Rehash row and column.
    assign n_rem      = mod_digit(r_rem, r_digits[HASH_W-1 -: DIGIT_W], cnt);
    assign rehash_col = KEY_BITS'(r_hin >> (HASH_W - KEY_BITS));

    // Read port A serves the old value and the rehash lookup, port B the new value.
    always_comb begin
        rd_en_a   = 1'b0;
        rd_addr_a = {ROW_W'(i_in.slot), KEY_BITS'(i_in.old_value)};
        rd_en_b   = in_acc && (i_in.kind == KIND_ELEMENT);
        rd_addr_b = {ROW_W'(i_in.slot), KEY_BITS'(i_in.new_value)};
        if (in_acc && (i_in.kind == KIND_ELEMENT)) begin
            rd_en_a = 1'b1;
        end else if ((r_state == S_MOD) && (r_step == STEP_W'(MOD_STEPS - 1))) begin
            rd_en_a   = 1'b1;
            rd_addr_a = {ROW_W'(n_rem), rehash_col};
        end
    end

    // Contribution test and the next running hash of an element.
    always_comb begin
        in_use     = int'(r_slot) < int'(cnt);
        if (!in_use) begin
            contrib = 1'b0;
        end else if (r_whole) begin
            contrib = (r_old != r_new);
        end else if (int'(r_group) < GROUPS) begin
            contrib = r_sel_mask[r_slot];
        end else begin
            contrib = 1'b0;
        end
        base_hash  = r_first ? r_hin : r_run_hash;
        n_zero     = (r_first ? 1'b0 : r_zero) | r_nprev;
        n_run_hash = contrib ? (base_hash ^ r_rd_a ^ r_rd_b) : base_hash;
    end

    // Key memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= i_in.key_word;
        end
        if (rd_en_a) begin
            r_rd_a <= key_mem[rd_addr_a];
        end
        if (rd_en_b) begin
            r_rd_b <= key_mem[rd_addr_b];
        end
    end

    // Group mask table, read on the edge that takes an element word.
    always_ff @(posedge i_clk) begin
        if (mask_we) begin
            mask_mem[GSEL_W'(i_in.group)] <= i_in.group_mask;
        end
        if (in_acc && (i_in.kind == KIND_ELEMENT)) begin
            r_sel_mask <= mask_mem[GSEL_W'(i_in.group)];
        end
    end

    // Sequencer, architectural state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_hash  <= '0;
            r_zero      <= 1'b0;
            r_slots_cfg <= SLOTS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slots_cfg <= i_cfg_wdata;
            end
            if (o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_slot   <= i_in.slot;
                        r_old    <= i_in.old_value;
                        r_new    <= i_in.new_value;
                        r_group  <= i_in.group;
                        r_whole  <= i_in.whole_vector;
                        r_first  <= i_in.first_of_vector;
                        r_last   <= i_in.last_of_vector;
                        r_nprev  <= i_in.no_previous;
                        r_hin    <= i_in.hash_in;
                        r_digits <= i_in.hash_in;
                        r_rem    <= '0;
                        r_step   <= '0;
                        if (i_in.kind == KIND_ELEMENT) begin
                            r_state <= S_ELEM;
                        end else if (i_in.kind == KIND_REHASH) begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_ELEM: begin
                    // A finishing element waits for room in the output register.
                    if (!r_last || out_free) begin
                        r_run_hash <= n_run_hash;
                        r_zero     <= n_zero;
                        if (r_last) begin
                            r_out_valid <= 1'b1;
                            r_out_hash  <= n_zero ? '0 : n_run_hash;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_MOD: begin
                    r_rem    <= n_rem;
                    r_digits <= r_digits << DIGIT_W;
                    r_step   <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(MOD_STEPS - 1)) begin
                        r_state <= S_REHASH;
                    end
                end
                S_REHASH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hash  <= r_hin ^ r_rd_a;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.hash_out = r_out_hash;

endmodule

// ===== hw/rtl/zih_checker.sv =====
module zih_checker
    import zih_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [KIND_W-1:0] i_in_kind,
    input logic              i_in_last,
    input logic              i_in_nprev,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [HASH_W-1:0] i_out_hash
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // A stalled result holds its word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hash))
        else $error("stalled result changed or dropped");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // Table loads never produce a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_kind == KIND_LOAD_KEY || i_in_kind == KIND_LOAD_MASK)
        |=> !$rose(i_out_valid))
        else $error("load word produced a result");

    // A last element with no predecessor, taken while no result is pending, yields zero.
    a_no_prev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_kind == KIND_ELEMENT && i_in_last && i_in_nprev && !i_out_valid
        |=> ##1 (i_out_valid && i_out_hash == '0))
        else $error("no-previous vector did not hash to zero");

    // The rehash modulo and its final XOR keep the engine from taking new words.
    a_rehash_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_kind == KIND_REHASH
        |=> !i_in_ready ##1 !i_in_ready ##1 !i_in_ready ##1 !i_in_ready ##1 !i_in_ready
            ##1 !i_in_ready ##1 !i_in_ready ##1 !i_in_ready ##1 !i_in_ready)
        else $error("rehash accepted a word too early");

endmodule

bind zobrist_incremental_hash zih_checker u_zih_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_in_last   (i_in.last_of_vector),
    .i_in_nprev  (i_in.no_previous),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hash  (o_out.hash_out)
);

// ===== tb/sv/zih_tb_pkg.sv =====
`timescale 1ns / 1ps

package zih_tb_pkg;
    import zih_pkg::*;

    localparam int KEY_COLS = 1 << KEY_BITS;

    // One input word, field by field at the widths of the stream.
    typedef struct {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [VAL_W-1:0]   old_value;
        logic [VAL_W-1:0]   new_value;
        logic [GROUP_W-1:0] group;
        bit                 whole_vector;
        bit                 first_of_vector;
        bit                 last_of_vector;
        bit                 no_previous;
        logic [HASH_W-1:0]  hash_in;
        logic [HASH_W-1:0]  key_word;
        logic [MASK_W-1:0]  group_mask;
    } t_stream_word;

    // Mirrors the key memory, masks and running hash, and keeps the hashes still owed.
    class hash_scoreboard;
        logic [HASH_W-1:0] key_mem [SLOTS][KEY_COLS];
        logic [MASK_W-1:0] slot_masks [GROUPS];
        logic [HASH_W-1:0] running_hash;
        bit                zero_flag;
        logic [CFG_W-1:0]  slots_cfg;
        logic [HASH_W-1:0] owed_hashes [$];
        int                errors;

        function new();
            foreach (key_mem[r, c]) begin
                key_mem[r][c] = '0;
            end
            foreach (slot_masks[g]) begin
                slot_masks[g] = '0;
            end
            running_hash = '0;
            zero_flag    = 1'b0;
            slots_cfg    = SLOTS_RESET;
            errors       = 0;
        endfunction

        function void set_slots(logic [CFG_W-1:0] value);
            slots_cfg = value;
        endfunction

        // Slot count in force: zero acts as one and the count saturates at SLOTS.
        function int active_slots();
            int n;
            n = int'(slots_cfg);
            if (n == 0) begin
                n = 1;
            end
            if (n > SLOTS) begin
                n = SLOTS;
            end
            return n;
        endfunction

        function int owed();
            return owed_hashes.size();
        endfunction

        // Apply one accepted word and queue the hash it produces, if any.
        function void note_word(t_stream_word w);
            int                  n;
            logic [HASH_W-1:0]   row;
            logic [KEY_BITS-1:0] col;
            bit                  adds;
            n = active_slots();
            case (w.kind)
                KIND_LOAD_KEY: begin
                    if (int'(w.slot) < SLOTS) begin
                        key_mem[w.slot][w.new_value[KEY_BITS-1:0]] = w.key_word;
                    end
                end
                KIND_LOAD_MASK: begin
                    if (int'(w.group) < GROUPS) begin
                        slot_masks[w.group] = w.group_mask;
                    end
                end
                KIND_REHASH: begin
                    row = w.hash_in % HASH_W'(n);
                    col = w.hash_in[HASH_W-1 -: KEY_BITS];
                    owed_hashes.push_back(w.hash_in ^ key_mem[row][col]);
                end
                KIND_ELEMENT: begin
                    // The first element restarts the hash and clears the zero flag.
                    if (w.first_of_vector) begin
                        running_hash = w.hash_in;
                        zero_flag    = 1'b0;
                    end
                    if (w.no_previous) begin
                        zero_flag = 1'b1;
                    end
                    // Whole-vector mode skips unchanged slots; group mode follows the mask.
                    if (int'(w.slot) >= n) begin
                        adds = 1'b0;
                    end else if (w.whole_vector) begin
                        adds = (w.old_value != w.new_value);
                    end else if (int'(w.group) < GROUPS) begin
                        adds = slot_masks[w.group][w.slot];
                    end else begin
                        adds = 1'b0;
                    end
                    if (adds) begin
                        running_hash ^= key_mem[w.slot][w.old_value[KEY_BITS-1:0]];
                        running_hash ^= key_mem[w.slot][w.new_value[KEY_BITS-1:0]];
                    end
                    if (w.last_of_vector) begin
                        owed_hashes.push_back(zero_flag ? {HASH_W{1'b0}} : running_hash);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one delivered hash with the oldest one owed.
        function void check_hash(logic [HASH_W-1:0] actual);
            logic [HASH_W-1:0] wanted;
            if (owed_hashes.size() == 0) begin
                $display("%0t: unexpected hash word, expected none, actual %h", $time, actual);
                errors++;
            end else begin
                wanted = owed_hashes.pop_front();
                if (actual !== wanted) begin
                    $display("%0t: hash mismatch, expected %h, actual %h",
                             $time, wanted, actual);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import zih_pkg::*;
    import zih_tb_pkg::*;

    localparam int HOLD_CYCLES   = 150;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 190;

    // Key columns the stimulus uses: sixteen values spread over the range, 0x00 to 0xFF.
    localparam int COLS_USED = 16;
    localparam int COL_STEP  = 17;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    zih_in_if  in_if ();
    zih_out_if out_if ();

    hash_scoreboard sb = new();

    bit idle_on      = 1'b1;
    bit hold_req     = 1'b0;
    int quiet_cycles = 0;

    zobrist_incremental_hash dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: short random stalls, and one long hold-off when requested.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left   = $urandom_range(1, 5) - 1;
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    // Check every delivered word and end the run if traffic stops.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_if.valid && out_if.ready) begin
                sb.check_hash(out_if.hash_out);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("zobrist_incremental_hash test failed");
                    $finish;
                end
            end
        end
    end

    task automatic put_fields(input t_stream_word w);
        in_if.kind            = w.kind;
        in_if.slot            = w.slot;
        in_if.old_value       = w.old_value;
        in_if.new_value       = w.new_value;
        in_if.group           = w.group;
        in_if.whole_vector    = w.whole_vector;
        in_if.first_of_vector = w.first_of_vector;
        in_if.last_of_vector  = w.last_of_vector;
        in_if.no_previous     = w.no_previous;
        in_if.hash_in         = w.hash_in;
        in_if.key_word        = w.key_word;
        in_if.group_mask      = w.group_mask;
    endtask

    // Offer one word from a falling edge and return at the falling edge after it is taken.
    task automatic send_word(input t_stream_word w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_if.valid = 1'b1;
        put_fields(w);
        do begin
            @(posedge clk);
        end while (!in_if.ready);
        sb.note_word(w);
        @(negedge clk);
    endtask

    // A value whose key column is loaded before any element or rehash reads it.
    function automatic logic [VAL_W-1:0] pick_value();
        return VAL_W'(COL_STEP * $urandom_range(0, COLS_USED - 1));
    endfunction

    function automatic t_stream_word random_word(t_kind kind);
        t_stream_word w;
        w.kind            = kind;
        w.slot            = SLOT_W'($urandom);
        w.old_value       = pick_value();
        w.new_value       = pick_value();
        w.group           = GROUP_W'($urandom);
        w.whole_vector    = 1'($urandom_range(0, 1));
        w.first_of_vector = 1'($urandom_range(0, 1));
        w.last_of_vector  = 1'($urandom_range(0, 1));
        w.no_previous     = 1'($urandom_range(0, 1));
        w.hash_in         = {$urandom, $urandom};
        w.key_word        = {$urandom, $urandom};
        w.group_mask      = MASK_W'($urandom);
        if (kind == KIND_REHASH) begin
            w.hash_in[HASH_W-1 -: KEY_BITS] = KEY_BITS'(pick_value());
        end
        return w;
    endfunction

    function automatic t_stream_word element_word(
        input logic [SLOT_W-1:0]  slot,
        input logic [VAL_W-1:0]   old_value,
        input logic [VAL_W-1:0]   new_value,
        input bit                 whole,
        input logic [GROUP_W-1:0] group,
        input bit                 first,
        input bit                 last,
        input bit                 no_prev,
        input logic [HASH_W-1:0]  hash_in
    );
        t_stream_word w;
        w                 = random_word(KIND_ELEMENT);
        w.slot            = slot;
        w.old_value       = old_value;
        w.new_value       = new_value;
        w.whole_vector    = whole;
        w.group           = group;
        w.first_of_vector = first;
        w.last_of_vector  = last;
        w.no_previous     = no_prev;
        w.hash_in         = hash_in;
        return w;
    endfunction

    // The slot count changes only once the engine has drained and gone quiet.
    task automatic write_slots(input logic [CFG_W-1:0] value);
        in_if.valid = 1'b0;
        while (sb.owed() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_slots(value);
    endtask

    // A well-formed vector: the first element carries the previous hash, the last emits.
    task automatic send_vector(input int len);
        t_stream_word       w;
        bit                 whole;
        logic [GROUP_W-1:0] grp;
        whole = 1'($urandom_range(0, 1));
        grp   = GROUP_W'($urandom);
        for (int i = 0; i < len; i++) begin
            w = random_word(KIND_ELEMENT);
            if ($urandom_range(0, 9) == 0) begin
                whole = !whole;
            end
            w.whole_vector    = whole;
            w.group           = grp;
            w.first_of_vector = (i == 0);
            w.last_of_vector  = (i == len - 1);
            w.no_previous     = ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 4) != 0) begin
                w.slot = SLOT_W'($urandom_range(0, sb.active_slots() - 1));
            end
            if ($urandom_range(0, 3) == 0) begin
                w.new_value = w.old_value;
            end
            send_word(w);
        end
    endtask

    // Mostly whole vectors, mixed with rehashes, table reloads and stray elements.
    task automatic run_phase(input logic [CFG_W-1:0] cfg, input bit long_hold);
        t_stream_word w;
        int           sent;
        int           pick;
        int           len;
        write_slots(cfg);
        if (long_hold) begin
            hold_req = 1'b1;
        end
        sent = 0;
        while (sent < PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(1, 6);
                send_vector(len);
                sent += len;
            end else begin
                if (pick < 80) begin
                    w = random_word(KIND_REHASH);
                    case ($urandom_range(0, 3))
                        0: w.hash_in = '1;
                        1: w.hash_in = HASH_W'($urandom_range(0, 255));
                        default: begin
                        end
                    endcase
                end else if (pick < 87) begin
                    w = random_word(KIND_LOAD_KEY);
                end else if (pick < 92) begin
                    w = random_word(KIND_LOAD_MASK);
                end else begin
                    w = random_word(KIND_ELEMENT);
                end
                send_word(w);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        t_stream_word w;
        in_if.valid = 1'b0;
        put_fields(random_word(KIND_LOAD_KEY));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill every key column in use and every mask so no entry is read unwritten.
        for (int r = 0; r < SLOTS; r++) begin
            for (int c = 0; c < COLS_USED; c++) begin
                w           = random_word(KIND_LOAD_KEY);
                w.slot      = SLOT_W'(r);
                w.new_value = VAL_W'(c * COL_STEP);
                send_word(w);
            end
        end
        for (int g = 0; g < GROUPS; g++) begin
            w       = random_word(KIND_LOAD_MASK);
            w.group = GROUP_W'(g);
            send_word(w);
        end

        // Rehash at both ends of the seed range.
        w         = random_word(KIND_REHASH);
        w.hash_in = '0;
        send_word(w);
        w.hash_in = '1;
        send_word(w);

        // Full and empty group masks.
        w            = random_word(KIND_LOAD_MASK);
        w.group      = '0;
        w.group_mask = '1;
        send_word(w);
        w.group      = '1;
        w.group_mask = '0;
        send_word(w);

        // Whole-vector elements at the value extremes, then an unchanged slot.
        send_word(element_word(4'd0, 8'd0, 8'hFF, 1, 4'd0, 1, 1, 0, '1));
        send_word(element_word(4'd15, 8'hFF, 8'd0, 1, 4'd0, 1, 0, 0, '0));
        send_word(element_word(4'd3, 8'h55, 8'h55, 1, 4'd0, 0, 1, 0, '0));

        // Group mode: an unchanged selected slot cancels; an empty mask adds nothing.
        send_word(element_word(4'd5, 8'hAA, 8'hAA, 0, 4'd0, 1, 1, 0, {$urandom, $urandom}));
        send_word(element_word(4'd7, 8'h11, 8'h22, 0, 4'd15, 1, 1, 0, {$urandom, $urandom}));

        // No previous vector, and elements that continue without a first.
        send_word(element_word(4'd1, 8'h33, 8'h44, 1, 4'd0, 1, 0, 1, {$urandom, $urandom}));
        send_word(element_word(4'd2, 8'h55, 8'h66, 1, 4'd0, 0, 1, 0, '0));
        send_word(element_word(4'd4, 8'h99, 8'h88, 1, 4'd0, 0, 1, 0, '0));
        send_word(element_word(4'd6, 8'h77, 8'h99, 1, 4'd0, 1, 1, 0, {$urandom, $urandom}));
        send_word(element_word(4'd8, 8'h11, 8'h00, 0, 4'd0, 1, 0, 0, {$urandom, $urandom}));
        send_word(element_word(4'd9, 8'h22, 8'h33, 0, 4'd0, 0, 1, 1, '0));
        send_word(element_word(4'd10, 8'h44, 8'h55, 1, 4'd0, 0, 1, 0, '0));

        // Reload one key and use it straight away.
        w           = random_word(KIND_LOAD_KEY);
        w.slot      = 4'd2;
        w.new_value = 8'h77;
        send_word(w);
        send_word(element_word(4'd2, 8'h77, 8'h88, 1, 4'd0, 1, 1, 0, {$urandom, $urandom}));

        // Slot counts at and beyond the limits; the receiver holds off once.
        run_phase(CFG_W'(0), 1'b0);
        run_phase(CFG_W'(31), 1'b1);
        run_phase(CFG_W'(1), 1'b0);
        run_phase(CFG_W'(17), 1'b0);
        run_phase(CFG_W'(5), 1'b0);
        run_phase(CFG_W'($urandom_range(1, 16)), 1'b0);
        run_phase(CFG_W'(16), 1'b0);
        idle_on = 1'b0;
        run_phase(CFG_W'($urandom_range(0, 31)), 1'b0);

        in_if.valid = 1'b0;
        while (sb.owed() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed() == 0) begin
            $display("zobrist_incremental_hash test passed");
        end else begin
            $display("zobrist_incremental_hash test failed");
        end
        $finish;
    end

endmodule
